### rtl/assert_macros.svh
// Assertion macros used by the top level of the latency histogram block.
// Each macro checks on the rising edge of clk_i and is off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true at a clock edge out of reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### rtl/lhp_pkg.sv
// Package for the latency histogram block: opcodes, field widths and the
// per-mille percentile constants. No dependencies.
`timescale 1ns / 1ps

package lhp_pkg;

  // Item opcodes
  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  // Width of the reported bin fields and of the reported sample count
  localparam int unsigned OUT_W     = 10;
  localparam int unsigned CNT_OUT_W = 32;

  // Running counts are scaled by 1000 so the compare stays in integers
  localparam int unsigned SCALE_W = 10;
  localparam logic [SCALE_W-1:0] SCALE = 10'd1000;

  // Percentiles: 50.0, 90.0, 99.0 and 99.9 percent in per-mille
  localparam int unsigned NUM_PCT = 4;
  typedef logic [SCALE_W-1:0] permille_t;
  localparam permille_t PCT_PERMILLE [NUM_PCT] = '{10'd500, 10'd900, 10'd990, 10'd999};

endpackage

### rtl/latency_histogram_percentiles.sv
// Latency histogram with percentile summary: top level.
// Depends on lhp_pkg, lhp_ram and assert_macros.svh.
//
// After reset the block clears its bin memory one entry a cycle and accepts no
// item until the clearing pass is done. Then record items (opcode 0) may follow
// back to back: each one reads its bin from the memory, adds one in the next
// cycle and writes it back, with the last write forwarded when the next record
// hits the same bin. A query item (opcode 1) walks all bins through the single
// read port, one bin a cycle, and no item is taken during the walk. A query on
// an empty histogram answers in the next cycle. A query waits while an earlier
// query result has not been taken; records do not.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module latency_histogram_percentiles #(
  parameter int unsigned VALUE_BINS  = 1024,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [15:0] sample_value_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        valid_res_o,
  output logic [9:0]  min_value_o,
  output logic [9:0]  p50_value_o,
  output logic [9:0]  p90_value_o,
  output logic [9:0]  p99_value_o,
  output logic [9:0]  p999_value_o,
  output logic [31:0] sample_count_o
);

  localparam int unsigned BW = $clog2(VALUE_BINS);
  localparam int unsigned PW = COUNT_WIDTH + lhp_pkg::SCALE_W;
  localparam logic [BW-1:0] LastBin = BW'(VALUE_BINS - 1);
  localparam logic [16:0] BinLimit = 17'(VALUE_BINS);
  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } state_e;

  state_e state_q;

  // handshake
  logic accept, is_query, rec_accept, qry_accept, qry_empty, out_load;

  // memory ports
  logic                   ram_we, ram_re;
  logic [BW-1:0]          ram_waddr, ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;

  // record path
  logic [BW-1:0]          rec_bin;
  logic                   rec_v_q;
  logic [BW-1:0]          rec_addr_q;
  logic [COUNT_WIDTH-1:0] rec_old, rec_new;
  logic                   fwd_v_q;
  logic [BW-1:0]          fwd_addr_q;
  logic [COUNT_WIDTH-1:0] fwd_data_q;
  logic [COUNT_WIDTH-1:0] sample_total_q;

  // walk control
  logic [BW-1:0] clr_addr_q, walk_addr_q;

  // walk pipeline
  logic                   s1_v_q, s2_v_q, s3_v_q;
  logic [BW-1:0]          s1_idx_q, s2_idx_q, s3_idx_q;
  logic [COUNT_WIDTH-1:0] run_q;
  logic [COUNT_WIDTH:0]   run_sum;
  logic [PW-1:0]          prod_q;
  logic [PW-1:0]          thr_q [lhp_pkg::NUM_PCT];
  logic                   have_min_q;
  logic [BW-1:0]          min_q;
  logic [lhp_pkg::NUM_PCT-1:0] found_q, found_d;
  logic [BW-1:0]          res_q [lhp_pkg::NUM_PCT];
  logic [BW-1:0]          res_d [lhp_pkg::NUM_PCT];
  logic                   walk_done;

  // output register
  logic        out_valid_q, valid_res_q;
  logic [9:0]  min_value_q, p50_value_q, p90_value_q, p99_value_q, p999_value_q;
  logic [31:0] sample_count_q;

  // ---------------------------------------------------------------------------
  // Input handshake: a query needs a free output register
  assign is_query   = (opcode_i == lhp_pkg::OP_QUERY);
  assign in_ready_o = (state_q == ST_IDLE) && !(is_query && out_valid_q);
  assign accept     = in_valid_i && in_ready_o;
  assign rec_accept = accept && !is_query;
  assign qry_accept = accept && is_query;
  assign qry_empty  = (sample_total_q == '0);

  // Values above the top bin go into it
  assign rec_bin = ({1'b0, sample_value_i} >= BinLimit) ? LastBin : BW'(sample_value_i);

  // ---------------------------------------------------------------------------
  // Memory port selection
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = rec_bin;
    if (state_q == ST_WALK) begin
      ram_re    = 1'b1;
      ram_raddr = walk_addr_q;
    end else if (rec_accept) begin
      ram_re = 1'b1;
    end
  end

  // Record increment, with the previous write forwarded on a bin hit
  assign rec_old = (fwd_v_q && (fwd_addr_q == rec_addr_q)) ? fwd_data_q : ram_rdata;
  assign rec_new = (rec_old == CountMax) ? rec_old : rec_old + 1'b1;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rec_addr_q;
    ram_wdata = rec_new;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else if (rec_v_q) begin
      ram_we = 1'b1;
    end
  end

  lhp_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(VALUE_BINS)
  ) u_bins (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Record pipeline and saturating total
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_v_q        <= 1'b0;
      fwd_v_q        <= 1'b0;
      sample_total_q <= '0;
    end else begin
      rec_v_q <= rec_accept;
      fwd_v_q <= rec_v_q;
      if (rec_accept && (sample_total_q != CountMax)) begin
        sample_total_q <= sample_total_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_accept) begin
      rec_addr_q <= rec_bin;
    end
    fwd_addr_q <= rec_addr_q;
    fwd_data_q <= rec_new;
  end

  // ---------------------------------------------------------------------------
  // Walk pipeline: stage 1 accumulates, stage 2 scales, stage 3 compares
  assign run_sum = {1'b0, run_q} + {1'b0, ram_rdata};

  always_comb begin
    found_d = found_q;
    for (int i = 0; i < lhp_pkg::NUM_PCT; i++) begin
      res_d[i] = res_q[i];
      if (s3_v_q && !found_q[i] && (prod_q >= thr_q[i])) begin
        res_d[i]   = s3_idx_q;
        found_d[i] = 1'b1;
      end
    end
  end

  assign walk_done = s3_v_q && (s3_idx_q == LastBin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= (state_q == ST_WALK);
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= walk_addr_q;
    s2_idx_q <= s1_idx_q;
    s3_idx_q <= s2_idx_q;
    if (qry_accept) begin
      run_q      <= '0;
      have_min_q <= 1'b0;
      min_q      <= '0;
      found_q    <= '0;
      for (int i = 0; i < lhp_pkg::NUM_PCT; i++) begin
        res_q[i] <= LastBin;
        thr_q[i] <= PW'(sample_total_q) * PW'(lhp_pkg::PCT_PERMILLE[i]);
      end
    end else begin
      if (s1_v_q) begin
        run_q <= run_sum[COUNT_WIDTH] ? CountMax : run_sum[COUNT_WIDTH-1:0];
        if ((ram_rdata != '0) && !have_min_q) begin
          have_min_q <= 1'b1;
          min_q      <= s1_idx_q;
        end
      end
      found_q <= found_d;
      for (int i = 0; i < lhp_pkg::NUM_PCT; i++) begin
        res_q[i] <= res_d[i];
      end
    end
    prod_q <= PW'(run_q) * PW'(lhp_pkg::SCALE);
  end

  // ---------------------------------------------------------------------------
  // Sequencer: clearing pass, bin walk and output register
  assign out_load = (qry_accept && qry_empty) || walk_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_addr_q     <= '0;
      walk_addr_q    <= '0;
      out_valid_q    <= 1'b0;
      valid_res_q    <= 1'b0;
      min_value_q    <= '0;
      p50_value_q    <= '0;
      p90_value_q    <= '0;
      p99_value_q    <= '0;
      p999_value_q   <= '0;
      sample_count_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == LastBin) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (qry_accept) begin
            walk_addr_q <= '0;
            if (qry_empty) begin
              out_valid_q    <= 1'b1;
              valid_res_q    <= 1'b0;
              min_value_q    <= '0;
              p50_value_q    <= '0;
              p90_value_q    <= '0;
              p99_value_q    <= '0;
              p999_value_q   <= '0;
              sample_count_q <= '0;
            end else begin
              state_q <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          walk_addr_q <= walk_addr_q + 1'b1;
          if (walk_addr_q == LastBin) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (walk_done) begin
            state_q        <= ST_IDLE;
            out_valid_q    <= 1'b1;
            valid_res_q    <= 1'b1;
            min_value_q    <= lhp_pkg::OUT_W'(min_q);
            p50_value_q    <= lhp_pkg::OUT_W'(res_d[0]);
            p90_value_q    <= lhp_pkg::OUT_W'(res_d[1]);
            p99_value_q    <= lhp_pkg::OUT_W'(res_d[2]);
            p999_value_q   <= lhp_pkg::OUT_W'(res_d[3]);
            sample_count_q <= lhp_pkg::CNT_OUT_W'(sample_total_q);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign valid_res_o    = valid_res_q;
  assign min_value_o    = min_value_q;
  assign p50_value_o    = p50_value_q;
  assign p90_value_o    = p90_value_q;
  assign p99_value_o    = p99_value_q;
  assign p999_value_o   = p999_value_q;
  assign sample_count_o = sample_count_q;

  // ---------------------------------------------------------------------------
  // Assertions
  `ASSERT_NEVER(a_no_item_in_clear, (state_q == ST_CLEAR) && in_ready_o, "item taken during clear")
  `ASSERT_NEVER(a_no_write_in_walk, rec_v_q && (state_q == ST_WALK), "record write during bin walk")
  `ASSERT_NEVER(a_no_result_overrun, out_load && out_valid_q && !out_ready_i, "result overwritten")
  `ASSERT_ALWAYS(a_total_monotonic, 1'b1 |=> (sample_total_q >= $past(sample_total_q)), "total fell")

endmodule

### rtl/lhp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module lhp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### dv/latency_histogram_percentiles_tb.sv
// Self-checking testbench for latency_histogram_percentiles: records samples, queries the
// percentile summary and compares every summary with a local histogram predictor.
// Depends on lhp_pkg and the latency_histogram_percentiles RTL.
`timescale 1ns / 1ps

module latency_histogram_percentiles_tb;

  localparam int unsigned VALUE_BINS  = 1024;
  localparam int unsigned COUNT_WIDTH = 32;
  localparam logic [9:0]  BIN_TOP     = 10'(VALUE_BINS - 1);
  localparam logic [63:0] COUNT_MAX   = (64'd1 << COUNT_WIDTH) - 64'd1;
  // Worst case is every item a full bin walk with long output stalls, taken a few times over
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  // Shapes of the sample bursts in the random part
  typedef enum int {
    SHAPE_CLUSTER,
    SHAPE_UNIFORM,
    SHAPE_WIDE,
    SHAPE_TAIL
  } spread_e;

  // One expected summary
  typedef struct packed {
    logic                             valid;
    logic [9:0]                       min_bin;
    logic [lhp_pkg::NUM_PCT-1:0][9:0] pct;
    logic [31:0]                      count;
  } bin_summary_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic        opcode_i       = lhp_pkg::OP_RECORD;
  logic [15:0] sample_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic        valid_res_o;
  logic [9:0]  min_value_o;
  logic [9:0]  p50_value_o;
  logic [9:0]  p90_value_o;
  logic [9:0]  p99_value_o;
  logic [9:0]  p999_value_o;
  logic [31:0] sample_count_o;

  // Predictor state
  logic [COUNT_WIDTH-1:0] hist_bins [VALUE_BINS];
  logic [COUNT_WIDTH-1:0] hist_total;
  bin_summary_t           pending_summaries [$];

  int send_idle_pct   = 0;
  int ready_stall_pct = 0;
  int error_count     = 0;
  int n_records       = 0;
  int n_queries       = 0;
  int n_summaries     = 0;
  int unsigned cycle_count = 0;

  latency_histogram_percentiles #(
    .VALUE_BINS (VALUE_BINS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .sample_value_i(sample_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .valid_res_o   (valid_res_o),
    .min_value_o   (min_value_o),
    .p50_value_o   (p50_value_o),
    .p90_value_o   (p90_value_o),
    .p99_value_o   (p99_value_o),
    .p999_value_o  (p999_value_o),
    .sample_count_o(sample_count_o)
  );

  // Clock: 12 ns period
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d summaries outstanding", $time, cycle_count,
               pending_summaries.size());
      $display("** latency_histogram_percentiles: FAILED **");
      $finish;
    end
  end

  // Receiver backpressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= ready_stall_pct);
  end

  // Store is cleared at reset
  initial begin
    for (int b = 0; b < VALUE_BINS; b++) hist_bins[b] = '0;
    hist_total = '0;
  end

  // Record one sample: values past the top bin land in it, counters saturate
  function automatic void record_sample(input logic [15:0] value);
    int unsigned bin;
    bin = (value >= VALUE_BINS) ? VALUE_BINS - 1 : value;
    if (hist_bins[bin] != '1) hist_bins[bin] = hist_bins[bin] + 1'b1;
    if (hist_total != '1) hist_total = hist_total + 1'b1;
  endfunction

  // Walk the bins: a percentile is the first bin whose running count times 1000
  // reaches the total times the per-mille fraction
  function automatic bin_summary_t compute_summary();
    bin_summary_t                s;
    logic [63:0]                 running;
    logic [lhp_pkg::NUM_PCT-1:0] hit;
    logic                        have_min;
    s = '0;
    if (hist_total == '0) return s;
    s.valid  = 1'b1;
    s.count  = 32'(hist_total);
    hit      = '0;
    have_min = 1'b0;
    running  = '0;
    for (int i = 0; i < lhp_pkg::NUM_PCT; i++) s.pct[i] = BIN_TOP;
    for (int b = 0; b < VALUE_BINS; b++) begin
      if (hist_bins[b] != '0 && !have_min) begin
        s.min_bin = 10'(b);
        have_min  = 1'b1;
      end
      running = running + 64'(hist_bins[b]);
      if (running > COUNT_MAX) running = COUNT_MAX;
      for (int i = 0; i < lhp_pkg::NUM_PCT; i++) begin
        if (!hit[i] &&
            running * 64'd1000 >= 64'(hist_total) * 64'(lhp_pkg::PCT_PERMILLE[i])) begin
          s.pct[i] = 10'(b);
          hit[i]   = 1'b1;
        end
      end
    end
    return s;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    end
  endfunction

  // Summary checker: sampled at the falling edge, so the item is taken at the next rise
  always @(negedge clk_i) begin
    bin_summary_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_summaries.size() == 0) begin
        $display("%0t: unexpected summary item: expected none, actual count %0d", $time,
                 sample_count_o);
        error_count++;
      end else begin
        want = pending_summaries.pop_front();
        n_summaries++;
        check_field("valid_res", 32'(want.valid), 32'(valid_res_o));
        check_field("min_value", 32'(want.min_bin), 32'(min_value_o));
        check_field("p50_value", 32'(want.pct[0]), 32'(p50_value_o));
        check_field("p90_value", 32'(want.pct[1]), 32'(p90_value_o));
        check_field("p99_value", 32'(want.pct[2]), 32'(p99_value_o));
        check_field("p999_value", 32'(want.pct[3]), 32'(p999_value_o));
        check_field("sample_count", want.count, sample_count_o);
      end
    end
  end

  // Send one item; entered and left at a rising edge. The predictor runs at the
  // falling edge before the edge that takes the item.
  task automatic send_item(input lhp_pkg::op_e op, input logic [15:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    sample_value_i <= value;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    if (op == lhp_pkg::OP_RECORD) begin
      record_sample(value);
      n_records++;
    end else begin
      pending_summaries.push_back(compute_summary());
      n_queries++;
    end
    @(posedge clk_i);
  endtask

  // Hold the sender off until every summary has come back
  task automatic wait_all_summaries();
    in_valid_i <= 1'b0;
    while (pending_summaries.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_value(input spread_e shape, input logic [9:0] centre);
    case (shape)
      SHAPE_CLUSTER: return 16'(centre) + 16'($urandom_range(7));
      SHAPE_UNIFORM: return 16'($urandom_range(VALUE_BINS - 1));
      SHAPE_WIDE:    return 16'($urandom);
      default:       return ($urandom_range(9) == 0) ? 16'($urandom_range(VALUE_BINS - 1))
                                                     : 16'($urandom_range(31));
    endcase
  endfunction

  // Empty store answers invalid with all zeros, then a single sample at bin zero
  task automatic test_empty_histogram();
    send_item(lhp_pkg::OP_QUERY, 16'hFFFF);
    send_item(lhp_pkg::OP_RECORD, 16'h0000);
    send_item(lhp_pkg::OP_QUERY, 16'h0000);
  endtask

  // Values past the top bin, the top bin itself and alternating bit patterns
  task automatic test_range_extremes();
    send_item(lhp_pkg::OP_RECORD, 16'hFFFF);
    send_item(lhp_pkg::OP_RECORD, 16'(VALUE_BINS));
    send_item(lhp_pkg::OP_RECORD, 16'(VALUE_BINS - 1));
    send_item(lhp_pkg::OP_QUERY, 16'h5555);
    send_item(lhp_pkg::OP_RECORD, 16'h5555);
    send_item(lhp_pkg::OP_RECORD, 16'hAAAA);
    send_item(lhp_pkg::OP_RECORD, 16'h02AA);
    send_item(lhp_pkg::OP_RECORD, 16'h0155);
    send_item(lhp_pkg::OP_RECORD, 16'h0200);
    send_item(lhp_pkg::OP_QUERY, 16'hAAAA);
  endtask

  // Queries back to back: each must wait for the one before it
  task automatic test_back_to_back_queries();
    ready_stall_pct = 50;
    repeat (3) send_item(lhp_pkg::OP_QUERY, 16'($urandom));
    ready_stall_pct = 0;
  endtask

  // Sender waits for the store to go quiet, then records and queries again
  task automatic test_drain_pause();
    send_item(lhp_pkg::OP_RECORD, 16'd7);
    send_item(lhp_pkg::OP_RECORD, 16'd7);
    send_item(lhp_pkg::OP_QUERY, 16'd0);
    wait_all_summaries();
    send_item(lhp_pkg::OP_RECORD, 16'd3);
    send_item(lhp_pkg::OP_QUERY, 16'd0);
  endtask

  // Bursts of records of one shape, each closed by a query, now and then two
  task automatic test_random_rounds(input int idle_pct, input int stall_pct, input int budget);
    int          sent;
    int          burst;
    spread_e     shape;
    logic [9:0]  centre;
    send_idle_pct   = idle_pct;
    ready_stall_pct = stall_pct;
    sent = 0;
    while (sent < budget) begin
      shape  = spread_e'($urandom_range(3));
      centre = 10'($urandom_range(VALUE_BINS - 1));
      burst  = $urandom_range(20, 2);
      repeat (burst) send_item(lhp_pkg::OP_RECORD, pick_value(shape, centre));
      send_item(lhp_pkg::OP_QUERY, 16'($urandom));
      sent += burst + 1;
      if ($urandom_range(5) == 0) begin
        send_item(lhp_pkg::OP_QUERY, 16'($urandom));
        sent++;
      end
    end
    wait_all_summaries();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_histogram();
    test_range_extremes();
    test_back_to_back_queries();
    test_drain_pause();
    test_random_rounds(0, 0, 185);
    test_random_rounds(74, 0, 185);
    test_random_rounds(0, 74, 185);
    test_random_rounds(10, 10, 185);

    // Let any stray summary show up before the verdict
    wait_all_summaries();
    repeat (VALUE_BINS + 16) @(posedge clk_i);

    $display("Recorded %0d samples (values past the top bin included) and ran %0d queries",
             n_records, n_queries);
    $display("under four sender/receiver stall mixes; %0d summaries compared", n_summaries);
    if (error_count == 0 && pending_summaries.size() == 0) begin
      $display("** latency_histogram_percentiles: PASSED **");
    end else begin
      $display("** latency_histogram_percentiles: FAILED **");
    end
    $finish;
  end

endmodule
